// ----- hw/rtl/task_dependency_status_tracker_macros.svh -----
// ----------------------------------------------------------------------------
// Task dependency status tracker: assertion macros
// Concurrent assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef TASK_DEPENDENCY_STATUS_TRACKER_MACROS_SVH
`define TASK_DEPENDENCY_STATUS_TRACKER_MACROS_SVH
`ifndef SYNTH
// assertion sampled on clk, switched off while rst is high
`define TDST_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// assertion sampled on clk, also checked during reset
`define TDST_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TDST_ASSERT(label, clk, rst, prop, msg)
`define TDST_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ----- hw/rtl/tdst_pkg.sv -----
// ----------------------------------------------------------------------------
// tdst_pkg
// Shared types, codes and sizes of the task dependency status tracker.
// ----------------------------------------------------------------------------
package tdst_pkg;

   localparam int MAX_NODES   = 256;
   localparam int MAX_DEGREE  = 16;
   localparam int NODE_W      = 8;
   localparam int NCNT_W      = $clog2(MAX_NODES + 1);
   localparam int DEG_W       = $clog2(MAX_DEGREE + 1);
   localparam int DIDX_W      = $clog2(MAX_DEGREE);
   localparam int LIST_AW     = NODE_W + DIDX_W;
   localparam int LCNT_W      = 13;
   localparam int LINK_W      = 12;

   localparam logic [3:0] ST_RUNNING = 4'b0001;
   localparam logic [3:0] ST_READY   = 4'b0010;
   localparam logic [3:0] ST_ENABLED = 4'b0100;
   localparam logic [3:0] ST_DONE    = 4'b1000;

   typedef enum logic [2:0] {
      OP_ADD_NODE  = 3'd0,
      OP_ADD_LINK  = 3'd1,
      OP_SET_BITS  = 3'd2,
      OP_CLR_BITS  = 3'd3,
      OP_PROPAGATE = 3'd4
   } opcode_type;

   typedef enum logic [2:0] {
      ERR_OK         = 3'd0,
      ERR_BAD_INDEX  = 3'd1,
      ERR_TABLE_FULL = 3'd2,
      ERR_DEG_FULL   = 3'd3,
      ERR_NOT_DONE   = 3'd4
   } err_type;

   typedef enum logic [1:0] {
      EV_NONE,
      EV_EMIT,
      EV_WALK
   } ev_kind_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_READ,
      S_EVAL,
      S_W_RDS,
      S_W_RDST,
      S_W_CHK,
      S_W_RDP,
      S_W_RDPS,
      S_W_PCHK,
      S_W_EMIT
   } state_type;

   typedef struct packed {
      logic load_req;
      logic rd_first;
      logic eval_commit;
      logic walk_start;
      logic rd_succ;
      logic rd_snode;
      logic chk_s;
      logic rd_pred;
      logic rd_pstat;
      logic chk_p;
      logic walk_emit;
   } cmd_type;

   typedef struct packed {
      ev_kind_type ev_kind;
      logic        out_free;
      logic        s_blocked;
      logic        pcnt_zero;
      logic        p_not_done;
      logic        j_last;
      logic        i_last;
   } sts_type;

endpackage

// ----- hw/rtl/tdst_ctrl.sv -----
// ----------------------------------------------------------------------------
// tdst_ctrl
// Sequencer: steps each item through read, evaluate and successor walk.
// ----------------------------------------------------------------------------
`include "task_dependency_status_tracker_macros.svh"

module tdst_ctrl
   import tdst_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_valid) state_in = S_READ;
         S_READ:   state_in = S_EVAL;
         S_EVAL: begin
            unique case (sts.ev_kind)
               EV_WALK: state_in = S_W_RDS;
               EV_EMIT: if (sts.out_free) state_in = S_IDLE;
               default: state_in = S_IDLE;
            endcase
         end
         S_W_RDS:  state_in = S_W_RDST;
         S_W_RDST: state_in = S_W_CHK;
         S_W_CHK: begin
            if (sts.s_blocked || sts.pcnt_zero) state_in = S_W_EMIT;
            else state_in = S_W_RDP;
         end
         S_W_RDP:  state_in = S_W_RDPS;
         S_W_RDPS: state_in = S_W_PCHK;
         S_W_PCHK: begin
            if (sts.p_not_done || sts.j_last) state_in = S_W_EMIT;
            else state_in = S_W_RDP;
         end
         S_W_EMIT: begin
            if (sts.out_free) state_in = sts.i_last ? S_IDLE : S_W_RDS;
         end
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE:   cmd.load_req = req_valid;
         S_READ:   cmd.rd_first = 1'b1;
         S_EVAL: begin
            cmd.eval_commit = (sts.ev_kind == EV_EMIT) && sts.out_free;
            cmd.walk_start  = (sts.ev_kind == EV_WALK);
         end
         S_W_RDS:  cmd.rd_succ  = 1'b1;
         S_W_RDST: cmd.rd_snode = 1'b1;
         S_W_CHK:  cmd.chk_s    = 1'b1;
         S_W_RDP:  cmd.rd_pred  = 1'b1;
         S_W_RDPS: cmd.rd_pstat = 1'b1;
         S_W_PCHK: cmd.chk_p    = 1'b1;
         S_W_EMIT: cmd.walk_emit = sts.out_free;
         default:  cmd = '0;
      endcase
   end

   `TDST_ASSERT(a_commit_slot, clock, reset, cmd.eval_commit |-> sts.out_free, "commit without free output slot")
   `TDST_ASSERT(a_emit_slot, clock, reset, cmd.walk_emit |-> sts.out_free, "walk result without free output slot")
   `TDST_ASSERT(a_accept_read, clock, reset, (req_valid && req_ready) |=> (state_ff == S_READ), "accepted item not read")

endmodule

// ----- hw/rtl/tdst_dp.sv -----
// ----------------------------------------------------------------------------
// tdst_dp
// Datapath: node tables, link lists, walk counters and the output register.
// ----------------------------------------------------------------------------
`include "task_dependency_status_tracker_macros.svh"

module tdst_dp
   import tdst_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [2:0]        req_operation,
   input  logic [NODE_W-1:0] req_node_a,
   input  logic [NODE_W-1:0] req_node_b,
   input  logic [3:0]        req_status_bits,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_result_node,
   output logic [3:0]        rsp_result_status,
   output logic [LINK_W-1:0] rsp_result_link,
   output logic              rsp_changed,
   output logic [2:0]        rsp_error_code,
   output logic              rsp_last,
   input  cmd_type           cmd,
   output sts_type           sts
);

   // latched request
   opcode_type        op_ff;
   logic [NODE_W-1:0] a_ff, b_ff;
   logic [3:0]        bits_ff;

   logic [NCNT_W-1:0] node_count_ff;
   logic [LCNT_W-1:0] link_count_ff;

   logic [3:0]         status_mem [MAX_NODES];
   logic [DEG_W-1:0]   sc_mem     [MAX_NODES];
   logic [DEG_W-1:0]   pc_mem     [MAX_NODES];
   logic [NODE_W-1:0]  succ_mem   [MAX_NODES*MAX_DEGREE];
   logic [NODE_W-1:0]  pred_mem   [MAX_NODES*MAX_DEGREE];

   logic [3:0]        status_rd_ff;
   logic [DEG_W-1:0]  sc_rd_ff, pc_rd_ff;
   logic [NODE_W-1:0] succ_rd_ff, pred_rd_ff;

   // walk state
   logic [DEG_W-1:0]  cnt_ff, pcnt_ff;
   logic [DIDX_W-1:0] i_ff, j_ff;
   logic [3:0]        s_status_ff;
   logic              changed_ff, allp_ff;

   // output register
   logic              out_valid_ff;
   logic [7:0]        out_node_ff;
   logic [3:0]        out_status_ff;
   logic [LINK_W-1:0] out_link_ff;
   logic              out_changed_ff, out_last_ff;
   err_type           out_err_ff;

   // evaluation
   logic              a_ok, b_ok, full, deg_full, add_ok, link_ok, setclr_ok;
   logic [3:0]        a_st, walk_st;
   ev_kind_type       ev_kind;
   logic [7:0]        ev_node;
   logic [3:0]        ev_status;
   logic [LINK_W-1:0] ev_link;
   err_type           ev_err;
   logic              out_load;

   logic              st_we, st_re;
   logic [NODE_W-1:0] st_wa, st_ra;
   logic [3:0]        st_wd;
   logic              cnt_we;
   logic [NODE_W-1:0] sc_wa, pc_wa, pc_ra;
   logic [DEG_W-1:0]  sc_wd, pc_wd;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff   <= opcode_type'(req_operation);
         a_ff    <= req_node_a;
         b_ff    <= req_node_b;
         bits_ff <= req_status_bits;
      end
   end

   always_comb begin
      a_ok      = {1'b0, a_ff} < node_count_ff;
      b_ok      = {1'b0, b_ff} < node_count_ff;
      a_st      = a_ok ? status_rd_ff : 4'd0;
      full      = (node_count_ff == NCNT_W'(MAX_NODES));
      deg_full  = (sc_rd_ff == DEG_W'(MAX_DEGREE)) || (pc_rd_ff == DEG_W'(MAX_DEGREE));
      add_ok    = (op_ff == OP_ADD_NODE) && !full;
      link_ok   = (op_ff == OP_ADD_LINK) && a_ok && b_ok && !deg_full;
      setclr_ok = ((op_ff == OP_SET_BITS) || (op_ff == OP_CLR_BITS)) && a_ok;
      ev_kind   = EV_EMIT;
      ev_node   = a_ff;
      ev_status = a_st;
      ev_link   = '0;
      ev_err    = ERR_OK;
      unique case (op_ff)
         OP_ADD_NODE: begin
            ev_status = 4'd0;
            if (full) begin
               ev_node = 8'd0;
               ev_err  = ERR_TABLE_FULL;
            end else begin
               ev_node = node_count_ff[7:0];
            end
         end
         OP_ADD_LINK: begin
            if (!a_ok || !b_ok) ev_err = ERR_BAD_INDEX;
            else if (deg_full) ev_err = ERR_DEG_FULL;
            else ev_link = link_count_ff[LINK_W-1:0];
         end
         OP_SET_BITS: begin
            if (!a_ok) ev_err = ERR_BAD_INDEX;
            else ev_status = status_rd_ff | bits_ff;
         end
         OP_CLR_BITS: begin
            if (!a_ok) ev_err = ERR_BAD_INDEX;
            else ev_status = status_rd_ff & ~bits_ff;
         end
         OP_PROPAGATE: begin
            if (!a_ok) ev_err = ERR_BAD_INDEX;
            else if ((status_rd_ff & ST_DONE) == 4'd0) ev_err = ERR_NOT_DONE;
            else if (sc_rd_ff == '0) ev_kind = EV_NONE;
            else ev_kind = EV_WALK;
         end
         default: ev_kind = EV_NONE;
      endcase
   end

   assign walk_st = changed_ff ? (s_status_ff | ST_ENABLED | (allp_ff ? ST_READY : 4'd0))
                               : s_status_ff;

   // status table: one write, one read port
   always_comb begin
      st_we = (cmd.eval_commit && (add_ok || setclr_ok)) || (cmd.walk_emit && changed_ff);
      st_wa = cmd.walk_emit ? succ_rd_ff : (add_ok ? node_count_ff[7:0] : a_ff);
      st_wd = cmd.walk_emit ? walk_st : (add_ok ? 4'd0 : ev_status);
      st_re = cmd.rd_first || cmd.rd_snode || cmd.rd_pstat;
      st_ra = cmd.rd_snode ? succ_rd_ff : (cmd.rd_pstat ? pred_rd_ff : a_ff);
      cnt_we = cmd.eval_commit && (add_ok || link_ok);
      sc_wa  = add_ok ? node_count_ff[7:0] : a_ff;
      pc_wa  = add_ok ? node_count_ff[7:0] : b_ff;
      sc_wd  = add_ok ? '0 : sc_rd_ff + DEG_W'(1);
      pc_wd  = add_ok ? '0 : pc_rd_ff + DEG_W'(1);
      pc_ra  = cmd.rd_snode ? succ_rd_ff : b_ff;
   end

   always_ff @(posedge clock) begin
      if (st_we) status_mem[st_wa] <= st_wd;
      if (st_re) status_rd_ff <= status_mem[st_ra];
   end

   always_ff @(posedge clock) begin
      if (cnt_we) sc_mem[sc_wa] <= sc_wd;
      if (cmd.rd_first) sc_rd_ff <= sc_mem[a_ff];
   end

   always_ff @(posedge clock) begin
      if (cnt_we) pc_mem[pc_wa] <= pc_wd;
      if (cmd.rd_first || cmd.rd_snode) pc_rd_ff <= pc_mem[pc_ra];
   end

   always_ff @(posedge clock) begin
      if (cmd.eval_commit && link_ok) succ_mem[{a_ff, sc_rd_ff[DIDX_W-1:0]}] <= b_ff;
      if (cmd.rd_succ) succ_rd_ff <= succ_mem[{a_ff, i_ff}];
   end

   always_ff @(posedge clock) begin
      if (cmd.eval_commit && link_ok) pred_mem[{b_ff, pc_rd_ff[DIDX_W-1:0]}] <= a_ff;
      if (cmd.rd_pred) pred_rd_ff <= pred_mem[{succ_rd_ff, j_ff}];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= '0;
         link_count_ff <= '0;
      end else if (cmd.eval_commit) begin
         if (add_ok) node_count_ff <= node_count_ff + NCNT_W'(1);
         if (link_ok) link_count_ff <= link_count_ff + LCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.walk_start) begin
         cnt_ff <= sc_rd_ff;
         i_ff   <= '0;
      end
      if (cmd.chk_s) begin
         s_status_ff <= status_rd_ff;
         pcnt_ff     <= pc_rd_ff;
         j_ff        <= '0;
         allp_ff     <= 1'b1;
         changed_ff  <= ~sts.s_blocked;
      end
      if (cmd.chk_p) begin
         if (sts.p_not_done) allp_ff <= 1'b0;
         j_ff <= j_ff + DIDX_W'(1);
      end
      if (cmd.walk_emit) i_ff <= i_ff + DIDX_W'(1);
   end

   // output register
   assign out_load = cmd.eval_commit || cmd.walk_emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.eval_commit) begin
         out_node_ff    <= ev_node;
         out_status_ff  <= ev_status;
         out_link_ff    <= ev_link;
         out_changed_ff <= 1'b0;
         out_err_ff     <= ev_err;
         out_last_ff    <= 1'b1;
      end else if (cmd.walk_emit) begin
         out_node_ff    <= succ_rd_ff;
         out_status_ff  <= walk_st;
         out_link_ff    <= '0;
         out_changed_ff <= changed_ff;
         out_err_ff     <= ERR_OK;
         out_last_ff    <= sts.i_last;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_result_node   = out_node_ff;
   assign rsp_result_status = out_status_ff;
   assign rsp_result_link   = out_link_ff;
   assign rsp_changed       = out_changed_ff;
   assign rsp_error_code    = out_err_ff;
   assign rsp_last          = out_last_ff;

   always_comb begin
      sts.ev_kind    = ev_kind;
      sts.out_free   = !out_valid_ff || rsp_ready;
      sts.s_blocked  = (status_rd_ff & (ST_DONE | ST_RUNNING)) != 4'd0;
      sts.pcnt_zero  = (pc_rd_ff == '0);
      sts.p_not_done = (status_rd_ff & ST_DONE) == 4'd0;
      sts.j_last     = ({1'b0, j_ff} + DEG_W'(1)) == pcnt_ff;
      sts.i_last     = ({1'b0, i_ff} + DEG_W'(1)) == cnt_ff;
   end

   `TDST_ASSERT(a_node_bound, clock, reset, node_count_ff <= NCNT_W'(MAX_NODES), "node count beyond table")
   `TDST_ASSERT(a_rsp_source, clock, reset, $rose(out_valid_ff) |-> $past(out_load), "result without a load")
   `TDST_ASSERT(a_link_step, clock, reset, (cmd.eval_commit && link_ok) |=> (link_count_ff == $past(link_count_ff) + LCNT_W'(1)), "link count not advanced")

endmodule

// ----- hw/rtl/task_dependency_status_tracker.sv -----
// ----------------------------------------------------------------------------
// task_dependency_status_tracker
// Task graph scoreboard with node status, link lists and done propagation.
// ----------------------------------------------------------------------------
// One item at a time. Add node, add link, set and clear read in S_READ and
// are evaluated in S_EVAL, which loads the result into the output register;
// so does a propagate that fails its checks, and one with no successors
// ends in S_EVAL without a result item. A propagate walks the successors
// in link order, reading each successor, then its status and predecessor
// count and, unless it is blocked, each of its predecessors and their
// status; the predecessor scan stops at the first one that is not done.
// The walk is serial, and the single read port of the status table is
// shared by the node, its successors and their predecessors. A waiting
// output stalls the sequencer; the next item is taken as soon as the
// sequencer is idle, even if the last result has not yet been taken. No
// table is cleared: an entry is written when its node or link is added.

module task_dependency_status_tracker
   import tdst_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [2:0]        req_operation,
   input  logic [NODE_W-1:0] req_node_a,
   input  logic [NODE_W-1:0] req_node_b,
   input  logic [3:0]        req_status_bits,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_result_node,
   output logic [3:0]        rsp_result_status,
   output logic [LINK_W-1:0] rsp_result_link,
   output logic              rsp_changed,
   output logic [2:0]        rsp_error_code,
   output logic              rsp_last
);

   cmd_type cmd;
   sts_type sts;

   // sequencer
   tdst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // tables, walk counters and output item register
   tdst_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_operation     (req_operation),
      .req_node_a        (req_node_a),
      .req_node_b        (req_node_b),
      .req_status_bits   (req_status_bits),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_result_node   (rsp_result_node),
      .rsp_result_status (rsp_result_status),
      .rsp_result_link   (rsp_result_link),
      .rsp_changed       (rsp_changed),
      .rsp_error_code    (rsp_error_code),
      .rsp_last          (rsp_last),
      .cmd               (cmd),
      .sts               (sts)
   );

endmodule

// ----- tb/task_dependency_status_tracker_test.sv -----
// ----------------------------------------------------------------------------
// task_dependency_status_tracker_test
// Self-checking bench for the task graph scoreboard: a behavioural model of
// the graph predicts every result item, directed and random operations drive
// the request channel, and both channels idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module task_dependency_status_tracker_test
   import tdst_pkg::*;
();

   typedef struct {
      logic [7:0]  node;
      logic [3:0]  status;
      logic [11:0] link;
      logic        changed;
      logic [2:0]  err;
      logic        last;
   } rsp_item_type;

   // graph model and queue of expected result items
   class graph_scoreboard;
      int unsigned   n_nodes;
      int unsigned   n_links;
      logic [3:0]    status_tab[MAX_NODES];
      int unsigned   succ_n[MAX_NODES];
      int unsigned   pred_n[MAX_NODES];
      int unsigned   succ_of[MAX_NODES][MAX_DEGREE];
      int unsigned   pred_of[MAX_NODES][MAX_DEGREE];
      rsp_item_type  pending[$];
      int unsigned   n_errors;

      function void clear_graph();
         n_nodes = 0;
         n_links = 0;
         foreach (status_tab[i]) begin
            status_tab[i] = '0;
            succ_n[i] = 0;
            pred_n[i] = 0;
         end
      endfunction

      function void push(int unsigned node, logic [3:0] st, int unsigned link,
                         bit chg, err_type err, bit last);
         rsp_item_type r;
         r.node = node[7:0];
         r.status = st;
         r.link = link[11:0];
         r.changed = chg;
         r.err = err;
         r.last = last;
         pending.push_back(r);
      endfunction

      function bit preds_all_done(int unsigned n);
         for (int unsigned j = 0; j < pred_n[n]; j++)
            if (!(status_tab[pred_of[n][j]] & ST_DONE)) return 0;
         return 1;
      endfunction

      // note an accepted request item
      function void note_request(logic [2:0] op, logic [7:0] a, logic [7:0] b,
                                 logic [3:0] bits);
         bit         a_ok;
         logic [3:0] a_st;
         int unsigned s;
         bit          chg;
         a_ok = a < n_nodes;
         a_st = a_ok ? status_tab[a] : 4'h0;
         case (op)
            OP_ADD_NODE: begin
               if (n_nodes >= MAX_NODES) begin
                  push(0, 0, 0, 0, ERR_TABLE_FULL, 1);
               end else begin
                  status_tab[n_nodes] = '0;
                  succ_n[n_nodes] = 0;
                  pred_n[n_nodes] = 0;
                  push(n_nodes, 0, 0, 0, ERR_OK, 1);
                  n_nodes++;
               end
            end
            OP_ADD_LINK: begin
               if (!a_ok || b >= n_nodes)
                  push(a, a_st, 0, 0, ERR_BAD_INDEX, 1);
               else if (succ_n[a] >= MAX_DEGREE || pred_n[b] >= MAX_DEGREE)
                  push(a, a_st, 0, 0, ERR_DEG_FULL, 1);
               else begin
                  succ_of[a][succ_n[a]] = b;
                  succ_n[a] = succ_n[a] + 1;
                  pred_of[b][pred_n[b]] = a;
                  pred_n[b] = pred_n[b] + 1;
                  push(a, status_tab[a], n_links, 0, ERR_OK, 1);
                  n_links = (n_links + 1) & 13'h1fff;
               end
            end
            OP_SET_BITS, OP_CLR_BITS: begin
               if (!a_ok) push(a, 0, 0, 0, ERR_BAD_INDEX, 1);
               else begin
                  if (op == OP_SET_BITS) status_tab[a] = status_tab[a] | bits;
                  else status_tab[a] = status_tab[a] & ~bits;
                  push(a, status_tab[a], 0, 0, ERR_OK, 1);
               end
            end
            OP_PROPAGATE: begin
               if (!a_ok) push(a, 0, 0, 0, ERR_BAD_INDEX, 1);
               else if (!(a_st & ST_DONE)) push(a, a_st, 0, 0, ERR_NOT_DONE, 1);
               else
                  for (int unsigned i = 0; i < succ_n[a]; i++) begin
                     s = succ_of[a][i];
                     chg = 0;
                     if (!(status_tab[s] & (ST_DONE | ST_RUNNING))) begin
                        status_tab[s] |= ST_ENABLED;
                        if (preds_all_done(s)) status_tab[s] |= ST_READY;
                        chg = 1;
                     end
                     push(s, status_tab[s], 0, chg, ERR_OK, i + 1 == succ_n[a]);
                  end
            end
            default: ;  // unused codes give nothing
         endcase
      endfunction

      // compare one accepted result item with the oldest expectation
      function void check_result(rsp_item_type got);
         rsp_item_type exp_r;
         if (pending.size() == 0) begin
            $error("unexpected result item, node %0d", got.node);
            n_errors++;
            return;
         end
         exp_r = pending.pop_front();
         if (got.node !== exp_r.node) begin
            $error("result_node: expected %0d, got %0d", exp_r.node, got.node);
            n_errors++;
         end
         if (got.status !== exp_r.status) begin
            $error("result_status: expected %h, got %h", exp_r.status, got.status);
            n_errors++;
         end
         if (got.link !== exp_r.link) begin
            $error("result_link: expected %0d, got %0d", exp_r.link, got.link);
            n_errors++;
         end
         if (got.changed !== exp_r.changed) begin
            $error("changed: expected %b, got %b", exp_r.changed, got.changed);
            n_errors++;
         end
         if (got.err !== exp_r.err) begin
            $error("error_code: expected %0d, got %0d", exp_r.err, got.err);
            n_errors++;
         end
         if (got.last !== exp_r.last) begin
            $error("last: expected %b, got %b", exp_r.last, got.last);
            n_errors++;
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [2:0]        req_operation = '0;
   logic [NODE_W-1:0] req_node_a = '0;
   logic [NODE_W-1:0] req_node_b = '0;
   logic [3:0]        req_status_bits = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [7:0]        rsp_result_node;
   logic [3:0]        rsp_result_status;
   logic [LINK_W-1:0] rsp_result_link;
   logic              rsp_changed;
   logic [2:0]        rsp_error_code;
   logic              rsp_last;

   graph_scoreboard sb = new();

   // idling percentages, changed per phase
   int unsigned send_idle_pct = 13;
   int unsigned recv_idle_pct = 45;
   int unsigned quiet_cycles  = 0;
   // watchdog: stops the run when no item moves on either channel
   localparam int unsigned WATCHDOG_LIMIT = 20000;

   always #6 clock = ~clock;

   task_dependency_status_tracker i_dut (.*);

   // sample both channels on the rising edge
   always @(posedge clock) begin
      rsp_item_type r;
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_request(req_operation, req_node_a, req_node_b, req_status_bits);
         if (rsp_valid && rsp_ready) begin
            r.node = rsp_result_node;
            r.status = rsp_result_status;
            r.link = rsp_result_link;
            r.changed = rsp_changed;
            r.err = rsp_error_code;
            r.last = rsp_last;
            sb.check_result(r);
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // receiver: ready set at random on the falling edge
   always @(negedge clock)
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);

   // drive one request item and hold it until accepted; valid is dropped by
   // the next call or by wait_drained, never twice in one falling edge
   task automatic send_item(logic [2:0] op, logic [7:0] a, logic [7:0] b,
                            logic [3:0] bits);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_node_a <= a;
      req_node_b <= b;
      req_status_bits <= bits;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
   endtask

   // pick a node index, mostly valid
   function automatic logic [7:0] pick_node();
      if (sb.n_nodes == 0 || $urandom_range(9) == 0) return 8'($urandom_range(255));
      return 8'($urandom_range(sb.n_nodes - 1));
   endfunction

   task automatic random_item();
      int unsigned k;
      k = $urandom_range(99);
      if (k < 12 && sb.n_nodes < 60)
         send_item(OP_ADD_NODE, 8'($urandom), 8'($urandom), 4'($urandom));
      else if (k < 40)
         send_item(OP_ADD_LINK, pick_node(), pick_node(), 4'($urandom));
      else if (k < 58)
         send_item(OP_SET_BITS, pick_node(), 8'($urandom), 4'($urandom_range(15)));
      else if (k < 72)
         send_item(OP_CLR_BITS, pick_node(), 8'($urandom), 4'($urandom_range(15)));
      else if (k < 97)
         send_item(OP_PROPAGATE, pick_node(), 8'($urandom), 4'($urandom));
      else
         send_item(3'($urandom_range(7, 5)), 8'($urandom), 8'($urandom), 4'($urandom));
   endtask

   initial begin
      sb.clear_graph();
      sb.n_errors = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: errors on an empty table, then a small graph
      send_item(OP_ADD_LINK, 8'd0, 8'd0, 4'h0);
      send_item(OP_SET_BITS, 8'd255, 8'd0, 4'hf);
      send_item(OP_PROPAGATE, 8'd0, 8'd255, 4'h0);
      for (int i = 0; i < 4; i++) send_item(OP_ADD_NODE, 8'hff, 8'hff, 4'hf);
      send_item(OP_ADD_LINK, 8'd0, 8'd1, 4'h0);
      send_item(OP_ADD_LINK, 8'd0, 8'd2, 4'h0);
      send_item(OP_ADD_LINK, 8'd0, 8'd1, 4'h0);   // duplicate link
      send_item(OP_ADD_LINK, 8'd3, 8'd2, 4'h0);
      send_item(OP_ADD_LINK, 8'd2, 8'd2, 4'h0);   // self link
      send_item(OP_ADD_LINK, 8'd0, 8'd200, 4'h0); // bad destination
      send_item(OP_PROPAGATE, 8'd0, 8'd0, 4'h0);  // not done
      send_item(OP_SET_BITS, 8'd0, 8'd0, ST_DONE);
      send_item(OP_SET_BITS, 8'd1, 8'd0, ST_RUNNING);
      send_item(OP_PROPAGATE, 8'd0, 8'd0, 4'h0);
      send_item(OP_CLR_BITS, 8'd1, 8'd0, 4'hf);
      send_item(3'd5, 8'd0, 8'd0, 4'h0);          // unused code
      send_item(3'd7, 8'hff, 8'hff, 4'hf);
      send_item(OP_SET_BITS, 8'd3, 8'd0, 4'hf);
      send_item(OP_PROPAGATE, 8'd3, 8'd0, 4'h0);
      send_item(OP_PROPAGATE, 8'd1, 8'd0, 4'h0);  // node 1 is not done
      // degree full: fill node 3 successors
      for (int i = 0; i < MAX_DEGREE; i++) send_item(OP_ADD_LINK, 8'd3, 8'd1, 4'h0);
      send_item(OP_PROPAGATE, 8'd3, 8'd0, 4'h0);  // longest walk
      // sender holds off until all results are back
      wait_drained();

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 45 : 0;
         recv_idle_pct = (phase == 0) ? 45 : (phase == 1) ? 13 : 0;
         for (int n = 0; n < 37; n++) random_item();
      end

      wait_drained();
      repeat (1000) @(posedge clock);
      if (sb.n_errors == 0 && sb.pending.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
